// ===== hw/rtl/metl_pkg.sv =====
// Shared constants and types for the mesh edge to triangle linker.
`timescale 1ns / 1ps
`default_nettype none
package metl_pkg;
  localparam int MaxTriangles = 1024;
  localparam int NodeW = 24;
  localparam int SpinW = 16;
  localparam int SideW = 25;
  localparam logic [SideW-1:0] Unassigned = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_EDGE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [NodeW-1:0] item_id;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [NodeW-1:0] node_c;
    logic [SpinW-1:0] spin_a;
    logic [SpinW-1:0] spin_b;
    logic [SpinW-1:0] spin_c;
    logic [SpinW-1:0] spin_d;
    logic [2:0]       kind_in;
    logic             face_or_previous;
    logic [9:0]       slot;
  } in_t;

  typedef struct packed {
    logic [2:0]       kind_out;
    logic [SpinW-1:0] spin_out_a;
    logic [SpinW-1:0] spin_out_b;
    logic [SpinW-1:0] spin_out_c;
    logic [SpinW-1:0] spin_out_d;
    logic [NodeW-1:0] tri_ident;
    logic [SideW-1:0] side_edge_0;
    logic [SideW-1:0] side_edge_1;
    logic [SideW-1:0] side_edge_2;
    logic             spin_overflow;
    logic [1:0]       status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat
    logic start;     // swap banks
    logic load;      // write a triangle
    logic rd_issue;  // issue a table read (scan or readout)
    logic rd_prev;   // read address is in the previous bank
    logic scan_eval; // evaluate the triangle read last cycle
    logic read_eval; // form the readout result
    logic finish;    // load the output register
  } cmd_t;

  typedef struct packed {
    logic       is_face;
    logic [1:0] op;
    logic       cur_empty;
    logic       prev_empty;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/metl_if.sv =====
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none
interface metl_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/metl_datapath.sv =====
// Triangle tables, scan index, spin merge and result register.
`timescale 1ns / 1ps
`default_nettype none
module metl_datapath
  import metl_pkg::*;
#(
  parameter int MAX_TRIANGLES = MaxTriangles
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire in_t   in_data,
  input  wire cmd_t  cmd,
  output      stat_t stat,
  output      logic  last_idx,
  output      out_t  result
);
  localparam int IdxW = $clog2(MAX_TRIANGLES);
  localparam int CntW = $clog2(MAX_TRIANGLES + 1);
  localparam int AddrW = IdxW + 1;
  localparam int Depth = 2 ** AddrW;

  // One row per triangle: nodes, sides, spins, id.
  logic [3*NodeW-1:0] mem_nodes [Depth];
  logic [3*SideW-1:0] mem_sides [Depth];
  logic [2*SpinW-1:0] mem_spins [Depth];
  logic [NodeW-1:0]   mem_ids [Depth];

  in_t               item;
  logic              bank_select;
  logic [CntW-1:0]   current_count;
  logic [CntW-1:0]   previous_count;
  logic [IdxW-1:0]   idx;
  logic [AddrW-1:0]  rd_addr;
  logic [3*NodeW-1:0] rd_nodes;
  logic [3*SideW-1:0] rd_sides;
  logic [2*SpinW-1:0] rd_spins;
  logic [NodeW-1:0]   rd_id;
  logic [2:0]        kind;
  logic [SpinW-1:0]  set [4];
  logic              ovf;
  logic              load_full;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [3*SideW-1:0] wr_sides;
  logic [CntW-1:0]   scan_count;
  logic [IdxW-1:0]   slot_idx;

  assign stat.is_face    = item.face_or_previous;
  assign stat.op         = item.op;
  assign stat.cur_empty  = (current_count == '0);
  assign stat.prev_empty = (previous_count == '0);
  assign scan_count = cmd.rd_prev ? previous_count : current_count;
  assign last_idx = ({1'b0, idx} + (IdxW+1)'(1)) >= (IdxW+1)'(scan_count);
  assign slot_idx = IdxW'(item.slot);

  // Side matching and spin merge of the triangle read in the previous cycle.
  logic [SideW-1:0] side_new [3];
  logic [2:0]       kind_nx;
  logic [SpinW-1:0] set_nx [4];
  logic             ovf_nx;
  logic             hit1, hit2;
  logic [SpinW-1:0] s1, s2;
  logic [NodeW-1:0] na, nb;
  logic             m;
  always_comb begin
    kind_nx = kind;
    ovf_nx = ovf;
    for (int i = 0; i < 4; i++) set_nx[i] = set[i];
    s1 = rd_spins[SpinW-1:0];
    s2 = rd_spins[2*SpinW-1:SpinW];
    for (int k = 0; k < 3; k++) begin
      side_new[k] = rd_sides[k*SideW +: SideW];
      na = rd_nodes[k*NodeW +: NodeW];
      nb = rd_nodes[((k == 2) ? 0 : k + 1)*NodeW +: NodeW];
      m = (side_new[k] == Unassigned) &&
          ((item.node_a == na && item.node_b == nb) ||
           (item.node_a == nb && item.node_b == na));
      if (m) begin
        side_new[k] = {1'b0, item.item_id};
        hit1 = 1'b0;
        hit2 = 1'b0;
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < kind_nx && set_nx[i] == s1) hit1 = 1'b1;
          if (3'(i) < kind_nx && set_nx[i] == s2) hit2 = 1'b1;
        end
        if (!hit1) begin
          if (kind_nx >= 3'd4) ovf_nx = 1'b1;
          else begin
            set_nx[kind_nx[1:0]] = s1;
            kind_nx = kind_nx + 3'd1;
          end
        end
        if (!hit2) begin
          if (kind_nx >= 3'd4) ovf_nx = 1'b1;
          else begin
            set_nx[kind_nx[1:0]] = s2;
            kind_nx = kind_nx + 3'd1;
          end
        end
      end else begin
        hit1 = 1'b0;
        hit2 = 1'b0;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = {bank_select, current_count[IdxW-1:0]};
    wr_sides = {3{Unassigned}};
    if (cmd.load && current_count < CntW'(MAX_TRIANGLES)) wr_en = 1'b1;
    if (cmd.scan_eval) begin
      wr_en = 1'b0;
      wr_addr = rd_addr;
      wr_sides = {side_new[2], side_new[1], side_new[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_nodes[wr_addr] <= {item.node_c, item.node_b, item.node_a};
      mem_spins[wr_addr] <= {item.spin_b, item.spin_a};
      mem_ids[wr_addr]   <= item.item_id;
    end
    if (wr_en || cmd.scan_eval) mem_sides[wr_addr] <= wr_sides;
    if (cmd.rd_issue) begin
      rd_nodes <= mem_nodes[{bank_select ^ cmd.rd_prev,
                             cmd.read_eval ? slot_idx : idx}];
      rd_sides <= mem_sides[{bank_select ^ cmd.rd_prev,
                             cmd.read_eval ? slot_idx : idx}];
      rd_spins <= mem_spins[{bank_select ^ cmd.rd_prev,
                             cmd.read_eval ? slot_idx : idx}];
      rd_id    <= mem_ids[{bank_select ^ cmd.rd_prev,
                           cmd.read_eval ? slot_idx : idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select <= 1'b0;
      current_count <= '0;
      previous_count <= '0;
      idx <= '0;
    end else begin
      if (cmd.capture) idx <= '0;
      else if (cmd.rd_issue) idx <= last_idx ? '0 : idx + IdxW'(1);
      if (cmd.start) begin
        bank_select <= ~bank_select;
        previous_count <= current_count;
        current_count <= '0;
      end else if (wr_en) begin
        current_count <= current_count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      kind <= (in_data.kind_in > 3'd4) ? 3'd4 : in_data.kind_in;
      set[0] <= in_data.spin_a;
      set[1] <= in_data.spin_b;
      set[2] <= in_data.spin_c;
      set[3] <= in_data.spin_d;
      ovf <= 1'b0;
      rd_addr <= '0;
    end else begin
      if (cmd.load) load_full <= !wr_en;
      if (cmd.rd_issue) rd_addr <= {bank_select ^ cmd.rd_prev, idx};
      if (cmd.scan_eval) begin
        kind <= kind_nx;
        for (int i = 0; i < 4; i++) set[i] <= set_nx[i];
        ovf <= ovf_nx;
      end
    end
  end

  // Readout range check uses the counts at the time of the read.
  logic [CntW-1:0] rcount;
  logic            rok;
  assign rcount = item.face_or_previous ? previous_count : current_count;
  assign rok = 32'(item.slot) < 32'(rcount);

  out_t res_next;
  always_comb begin
    res_next = '0;
    case (op_t'(item.op))
      OP_LOAD: begin
        if (load_full) res_next.status = ST_FULL;
      end
      OP_EDGE: begin
        res_next.kind_out = kind;
        res_next.spin_out_a = set[0];
        res_next.spin_out_b = set[1];
        res_next.spin_out_c = set[2];
        res_next.spin_out_d = set[3];
        res_next.spin_overflow = ovf;
      end
      OP_READ: begin
        if (!rok) res_next.status = ST_RANGE;
        else begin
          res_next.spin_out_a = rd_spins[SpinW-1:0];
          res_next.spin_out_b = rd_spins[2*SpinW-1:SpinW];
          res_next.tri_ident = rd_id;
          res_next.side_edge_0 = rd_sides[SideW-1:0];
          res_next.side_edge_1 = rd_sides[2*SideW-1:SideW];
          res_next.side_edge_2 = rd_sides[3*SideW-1:2*SideW];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) result <= res_next;
  end

`ifndef SYNTHESIS
  a_kind_max: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> kind <= 3'd4) else $error("spin count above four");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    current_count <= CntW'(MAX_TRIANGLES)) else $error("count beyond table");
  a_no_dual: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.scan_eval)) else $error("load during scan");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/metl_ctrl.sv =====
// Controller state machine sequencing commands over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module metl_ctrl
  import metl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output      logic  in_ready,
  output      logic  out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  input  wire logic  last_idx,
  output      cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DRAIN, S_READ, S_DONE
  } state_t;
  state_t state, state_next;
  logic prev_phase, prev_phase_next;
  logic out_valid_next;
  // Within a scan the evaluation of triangle j overlaps the read of j+1.
  logic scan_prev;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    prev_phase_next = prev_phase;
    out_valid_next = out_valid && !out_ready;
    cmd.rd_prev = prev_phase;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          prev_phase_next = 1'b0;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_t'(stat.op))
          OP_START: begin cmd.start = 1'b1; state_next = S_DONE; end
          OP_LOAD:  begin cmd.load = 1'b1; state_next = S_DONE; end
          OP_EDGE: begin
            if (!stat.cur_empty) state_next = S_SCAN;
            else if (stat.is_face && !stat.prev_empty) begin
              prev_phase_next = 1'b1;
              state_next = S_SCAN;
            end else state_next = S_DONE;
          end
          default: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_prev = stat.is_face;
            cmd.read_eval = 1'b1;
            state_next = S_READ;
          end
        endcase
      end
      S_SCAN: begin
        // A read is issued while the triangle before it is evaluated.
        cmd.rd_issue = 1'b1;
        cmd.scan_eval = scan_prev;
        if (last_idx) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.scan_eval = 1'b1;
        if (!prev_phase && stat.is_face && !stat.prev_empty) begin
          prev_phase_next = 1'b1;
          state_next = S_SCAN;
        end else state_next = S_DONE;
      end
      S_READ: begin
        cmd.read_eval = 1'b1;
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev_phase <= 1'b0;
      out_valid <= 1'b0;
      scan_prev <= 1'b0;
    end else begin
      state <= state_next;
      prev_phase <= prev_phase_next;
      out_valid <= out_valid_next;
      scan_prev <= (state == S_SCAN);
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("result without finish");
  a_scan_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> scan_prev) else $error("drain without scan");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/mesh_edge_triangle_linker.sv =====
// Top level of the mesh edge to triangle linker.
`timescale 1ns / 1ps
`default_nettype none
// One command is handled at a time. Start layer and load triangle go from
// dispatch to the done state; readout issues its table read at dispatch and
// forms its result in the read state. An edge scans the current table when
// it is not empty and, for a face edge, the previous one when that is not
// empty, as the triangle table is read one triangle per cycle while matched
// sides are written back in the cycle after each read. No new beat is taken
// while a result waits on the output.
module mesh_edge_triangle_linker
  import metl_pkg::*;
#(
  parameter int MAX_TRIANGLES = MaxTriangles
) (
  input wire logic clk,
  input wire logic rst,
  metl_if.sink     in_ch,
  metl_if.source   out_ch
);
  cmd_t  cmd;
  stat_t stat;
  logic  last_idx;

  metl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .last_idx, .cmd
  );

  metl_datapath #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_dp (
    .clk, .rst, .in_data(in_ch.data), .cmd, .stat, .last_idx,
    .result(out_ch.data)
  );
endmodule
`default_nettype wire
